// File: src/clint_pkg.sv
// Shared types and constants for the core-local interruptor.
// Holds item kind codes, region codes, parameter defaults and the control word
// that the sequencer sends to the datapath. Depends on nothing.
package clint_pkg;

    localparam int HARTS_DEF        = 4;
    localparam int SOFT_BASE_DEF    = 0;
    localparam int COMPARE_BASE_DEF = 16384;
    localparam int TIME_BASE_DEF    = 49144;

    localparam int KIND_W   = 2;
    localparam int OFFSET_W = 16;
    localparam int SIZE_W   = 4;
    localparam int DATA_W   = 64;
    localparam int MASK_W   = 4;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    typedef enum logic [1:0] {
        REGION_NONE = 2'd0,
        REGION_SOFT = 2'd1,
        REGION_CMP  = 2'd2,
        REGION_TIME = 2'd3
    } region_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic execute;
        logic load_out;
    } clint_cmd_t;

endpackage

// File: src/clint_ctrl.sv
// Sequencer for the core-local interruptor: accept, decode, execute, deliver.
// Drives the input stall, the output valid and the datapath control word.
// Depends on clint_pkg.
module clint_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clint_pkg::clint_cmd_t cmd
);
    import clint_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEC  = 4'b0010,
        ST_EXE  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                cmd.decode = 1'b1;
                state_next = ST_EXE;
            end
            ST_EXE:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the result until the output word slot frees up
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/clint_dpath.sv
// Datapath for the core-local interruptor: input word latch, region decode,
// software/compare/time registers, byte-lane read and write, output register.
// Depends on clint_pkg.
module clint_dpath
#(
    parameter int HARTS        = clint_pkg::HARTS_DEF,
    parameter int SOFT_BASE    = clint_pkg::SOFT_BASE_DEF,
    parameter int COMPARE_BASE = clint_pkg::COMPARE_BASE_DEF,
    parameter int TIME_BASE    = clint_pkg::TIME_BASE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  clint_pkg::clint_cmd_t            cmd,
    input  logic [clint_pkg::KIND_W-1:0]     kind,
    input  logic [clint_pkg::OFFSET_W-1:0]   offset,
    input  logic [clint_pkg::SIZE_W-1:0]     size_bytes,
    input  logic [clint_pkg::DATA_W-1:0]     wdata,
    output logic [clint_pkg::DATA_W-1:0]     rdata,
    output logic                             access_ok,
    output logic [clint_pkg::MASK_W-1:0]     timer_irq_mask,
    output logic [clint_pkg::MASK_W-1:0]     soft_irq_mask
);
    import clint_pkg::*;

    localparam int REG_BYTES = HARTS * 8;
    localparam int REG_W     = REG_BYTES * 8;
    localparam int POS_W     = $clog2(REG_BYTES);
    localparam int ADDR_W    = OFFSET_W + 2;
    localparam int MASK_H    = (HARTS < MASK_W) ? HARTS : MASK_W;

    localparam logic [ADDR_W-1:0] SOFT_LO = ADDR_W'(SOFT_BASE);
    localparam logic [ADDR_W-1:0] SOFT_HI = ADDR_W'(SOFT_BASE + HARTS * 4);
    localparam logic [ADDR_W-1:0] CMP_LO  = ADDR_W'(COMPARE_BASE);
    localparam logic [ADDR_W-1:0] CMP_HI  = ADDR_W'(COMPARE_BASE + HARTS * 8);
    localparam logic [ADDR_W-1:0] TIME_LO = ADDR_W'(TIME_BASE);
    localparam logic [ADDR_W-1:0] TIME_HI = ADDR_W'(TIME_BASE + 8);

    // latched input word
    logic [KIND_W-1:0]   kind_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [DATA_W-1:0]   wdata_reg;

    // decode results
    region_t             region_reg, region_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    // device state
    logic [DATA_W-1:0]   time_reg, time_next;
    logic [DATA_W-1:0]   cmp_reg [HARTS];
    logic [DATA_W-1:0]   cmp_next [HARTS];
    logic [HARTS-1:0]    soft_reg, soft_next;

    // execute results
    logic [DATA_W-1:0]   rd_reg, rd_next;
    logic                ok_reg, ok_next;

    // output word
    logic [DATA_W-1:0]   rdata_reg;
    logic                ok_out_reg;
    logic [MASK_W-1:0]   tmask_reg, tmask_next;
    logic [MASK_W-1:0]   smask_reg, smask_next;

    // decode
    logic [ADDR_W-1:0]   off_ext, end_ext, base_sel, diff;
    logic                size_ok, is_access;
    logic                hit_soft, hit_cmp, hit_time;

    always_comb
    begin
        off_ext   = ADDR_W'(off_reg);
        end_ext   = off_ext + ADDR_W'(size_reg);
        size_ok   = (size_reg != '0) && (size_reg <= SIZE_W'(8));
        is_access = (kind_reg == KIND_READ) || (kind_reg == KIND_WRITE);
        hit_soft  = (off_ext >= SOFT_LO) && (end_ext <= SOFT_HI);
        hit_cmp   = (off_ext >= CMP_LO) && (end_ext <= CMP_HI);
        hit_time  = (off_ext >= TIME_LO) && (end_ext <= TIME_HI);
        region_next = REGION_NONE;
        base_sel    = '0;
        if (is_access && size_ok)
        begin
            // software region wins over compare, compare over time
            if (hit_soft)
            begin
                region_next = REGION_SOFT;
                base_sel    = SOFT_LO;
            end
            else if (hit_cmp)
            begin
                region_next = REGION_CMP;
                base_sel    = CMP_LO;
            end
            else if (hit_time)
            begin
                region_next = REGION_TIME;
                base_sel    = TIME_LO;
            end
        end
        diff     = off_ext - base_sel;
        pos_next = diff[POS_W-1:0];
    end

    // byte lanes of the selected region
    logic [7:0]          size_mask;
    logic [8:0]          size_one;
    logic [REG_BYTES-1:0] lane_mask;
    logic [REG_W-1:0]    wr_shift, src_soft, src_cmp, src_time, src_sel, rd_shift;
    logic [DATA_W-1:0]   rd_bytes_mask;
    logic                do_write;

    always_comb
    begin
        size_one  = 9'h1 << size_reg;
        size_mask = 8'(size_one - 9'h1);
        lane_mask = REG_BYTES'(size_mask) << pos_reg;
        wr_shift  = REG_W'(wdata_reg) << {pos_reg, 3'b000};
        do_write  = (kind_reg == KIND_WRITE);

        src_soft = '0;
        src_cmp  = '0;
        for (int h = 0; h < HARTS; h++)
        begin
            src_soft[32*h]          = soft_reg[h];
            src_cmp[64*h +: DATA_W] = cmp_reg[h];
        end
        src_time = REG_W'(time_reg);

        case (region_reg)
            REGION_SOFT: src_sel = src_soft;
            REGION_CMP:  src_sel = src_cmp;
            REGION_TIME: src_sel = src_time;
            default:     src_sel = '0;
        endcase
        rd_shift = src_sel >> {pos_reg, 3'b000};
        for (int b = 0; b < 8; b++)
            rd_bytes_mask[8*b +: 8] = {8{size_mask[b]}};
    end

    always_comb
    begin
        time_next = time_reg;
        soft_next = soft_reg;
        for (int h = 0; h < HARTS; h++)
            cmp_next[h] = cmp_reg[h];
        rd_next = '0;
        ok_next = 1'b0;

        if (kind_reg == KIND_TICK)
        begin
            time_next = time_reg + DATA_W'(1);
            ok_next   = 1'b1;
        end
        else if (region_reg != REGION_NONE)
        begin
            ok_next = 1'b1;
            if (!do_write)
                rd_next = rd_shift[DATA_W-1:0] & rd_bytes_mask;
        end

        if (do_write)
        begin
            case (region_reg)
                REGION_SOFT:
                begin
                    for (int h = 0; h < HARTS; h++)
                        if (lane_mask[4*h])
                            soft_next[h] = wr_shift[32*h];
                end
                REGION_CMP:
                begin
                    for (int j = 0; j < REG_BYTES; j++)
                        if (lane_mask[j])
                            cmp_next[j/8][8*(j%8) +: 8] = wr_shift[8*j +: 8];
                end
                REGION_TIME:
                begin
                    for (int j = 0; j < 8; j++)
                        if (lane_mask[j])
                            time_next[8*j +: 8] = wr_shift[8*j +: 8];
                end
                default:
                begin
                end
            endcase
        end
    end

    // interrupt masks from the state this item left behind
    always_comb
    begin
        tmask_next = '0;
        smask_next = '0;
        for (int h = 0; h < MASK_H; h++)
        begin
            tmask_next[h] = (time_reg >= cmp_reg[h]);
            smask_next[h] = soft_reg[h];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= kind;
            off_reg   <= offset;
            size_reg  <= size_bytes;
            wdata_reg <= wdata;
        end
        if (cmd.decode)
        begin
            region_reg <= region_next;
            pos_reg    <= pos_next;
        end
        if (cmd.execute)
        begin
            rd_reg <= rd_next;
            ok_reg <= ok_next;
        end
        if (cmd.load_out)
        begin
            rdata_reg  <= rd_reg;
            ok_out_reg <= ok_reg;
            tmask_reg  <= tmask_next;
            smask_reg  <= smask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            soft_reg <= '0;
            for (int h = 0; h < HARTS; h++)
                cmp_reg[h] <= '0;
        end
        else if (cmd.execute)
        begin
            time_reg <= time_next;
            soft_reg <= soft_next;
            for (int h = 0; h < HARTS; h++)
                cmp_reg[h] <= cmp_next[h];
        end
    end

    assign rdata          = rdata_reg;
    assign access_ok      = ok_out_reg;
    assign timer_irq_mask = tmask_reg;
    assign soft_irq_mask  = smask_reg;

endmodule

// File: src/core_local_interruptor_unit.sv
// Top level of the core-local interruptor: sequencer plus datapath.
// Depends on clint_pkg, clint_ctrl and clint_dpath.
//
// Input channel (in_valid/in_stall) carries one word per item: a read, a
// write or a timer tick (kind), with byte offset, size and write bytes.
// Output channel (out_valid/out_stall) returns one word per item: read
// bytes, an ok flag and the timer and software interrupt masks of harts 0
// to 3, as they stand after the item.
// From the input accept to out_valid, the word is latched at the accept
// edge, then registered by region decode, by register update, and by mask
// compare into the output register; that load waits while out_stall holds.
// The four-step sequencer handles one item at a time and takes no new item
// before it is through with the last one, so in_stall is high from the cycle
// after an accept until the result is loaded into the output register.
// The output register holds a finished word while the next item is taken
// in and worked on; if out_stall is still high when that next result is
// ready, the sequencer waits in its last step and in_stall stays high.
// Reset clears the time counter, all compare words, all software bits and
// the output valid; the block is ready for an item right after reset.
module core_local_interruptor_unit
#(
    parameter int HARTS        = clint_pkg::HARTS_DEF,
    parameter int SOFT_BASE    = clint_pkg::SOFT_BASE_DEF,
    parameter int COMPARE_BASE = clint_pkg::COMPARE_BASE_DEF,
    parameter int TIME_BASE    = clint_pkg::TIME_BASE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [clint_pkg::KIND_W-1:0]     kind,
    input  logic [clint_pkg::OFFSET_W-1:0]   offset,
    input  logic [clint_pkg::SIZE_W-1:0]     size_bytes,
    input  logic [clint_pkg::DATA_W-1:0]     wdata,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [clint_pkg::DATA_W-1:0]     rdata,
    output logic                             access_ok,
    output logic [clint_pkg::MASK_W-1:0]     timer_irq_mask,
    output logic [clint_pkg::MASK_W-1:0]     soft_irq_mask
);
    import clint_pkg::*;

    localparam int MASK_H = (HARTS < MASK_W) ? HARTS : MASK_W;

    clint_cmd_t cmd;

    clint_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    clint_dpath
    #(
        .HARTS        (HARTS),
        .SOFT_BASE    (SOFT_BASE),
        .COMPARE_BASE (COMPARE_BASE),
        .TIME_BASE    (TIME_BASE)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .offset         (offset),
        .size_bytes     (size_bytes),
        .wdata          (wdata),
        .rdata          (rdata),
        .access_ok      (access_ok),
        .timer_irq_mask (timer_irq_mask),
        .soft_irq_mask  (soft_irq_mask)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an accept");

    a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (access_ok || (rdata == '0)))
        else $error("failed access returned nonzero read data");

    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((timer_irq_mask >> MASK_H) == '0)
                       && ((soft_irq_mask >> MASK_H) == '0)))
        else $error("interrupt mask bit set for a missing hart");
`endif

endmodule
